// ===== design/nu3_pkg.sv =====
// ----------------------------------------------------------------------------
// nu3_pkg
// Shared types and constants for the 3-D nearest-neighbor 2x upsampler:
// register map, field widths and copy counter codes.
// ----------------------------------------------------------------------------
package nu3_pkg;

    // Configuration register map
    localparam int CFG_BITS      = 11;
    localparam int NUM_CFG       = 5;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        CFG_CHANNELS,
        CFG_IN_WIDTH,
        CFG_IN_HEIGHT,
        CFG_IN_DEPTH,
        CFG_BATCHES
    } cfg_idx_t;

    // Payload
    localparam int SAMPLE_BITS = 32;

    // Eight copies per sample, dx fastest, then dy, then dz
    localparam int COPY_BITS = 3;
    localparam logic [COPY_BITS-1:0] FIRST_COPY = 3'd0;
    localparam logic [COPY_BITS-1:0] LAST_COPY  = 3'd7;

    // Cycles the stride chain needs to follow a register change
    localparam int SETTLE_BITS = 2;
    localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = 2'd3;

endpackage

// ===== design/nearest_upsample_3d_x2.sv =====
// ----------------------------------------------------------------------------
// nearest_upsample_3d_x2
// Copies each channel-last input sample to the 2x2x2 block of an output
// volume twice as wide, high and deep, with the output element index.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  s_       | in        | s_valid / s_ready   | s_sample_bits
//  m_       | out       | m_valid / m_ready   | m_out_index, m_out_bits,
//           |           |                     | m_last_of_item, m_end_of_transfer
//  apb      | in        | psel/penable/pready | paddr, pwdata, prdata
//
//  m_valid rises for the first copy of a sample once it has passed index
//  stages s1 to s5; its eight copies then leave one per cycle while m_ready
//  is high, and the copy counter loads the next sample only after the last copy.
//  The five-stage index pipeline takes a new sample in every cycle that it
//  can move, so up to five samples wait behind the copies in flight.
//  After reset and after every register write s_ready stays low while the
//  stride chain settles. Stalls on m_ready hold all copies.
// ----------------------------------------------------------------------------
module nearest_upsample_3d_x2 #(
    parameter int DIM_BITS   = 10,
    parameter int INDEX_BITS = 40
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input samples
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [nu3_pkg::SAMPLE_BITS-1:0]    s_sample_bits,
    // output copies
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [INDEX_BITS-1:0]              m_out_index,
    output logic [nu3_pkg::SAMPLE_BITS-1:0]    m_out_bits,
    output logic                               m_last_of_item,
    output logic                               m_end_of_transfer,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nu3_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [nu3_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [nu3_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import nu3_pkg::*;

    localparam int EW = DIM_BITS + 1;
    localparam int CW = (EW > CFG_BITS) ? EW : CFG_BITS;
    localparam logic [CW-1:0] DIM_TOP = CW'(1) << DIM_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]    cfg_reg [NUM_CFG];
    logic [2:0]             cfg_sel;
    logic                   cfg_hit;
    logic                   cfg_write;
    logic [SETTLE_BITS-1:0] settle_reg;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_hit   = (cfg_sel < 3'(NUM_CFG));
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? APB_DATA_BITS'(cfg_reg[cfg_sel]) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= CFG_BITS'(1);
            end
            settle_reg <= SETTLE_CYCLES;
        end else begin
            if (cfg_write && cfg_hit) begin
                cfg_reg[cfg_sel] <= pwdata[CFG_BITS-1:0];
            end
            if (cfg_write) begin
                settle_reg <= SETTLE_CYCLES;
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - SETTLE_BITS'(1);
            end
        end
    end

    // Effective sizes: zero acts as one, clamp to the counter range
    logic [EW-1:0] eff_dim [NUM_CFG];

    for (genvar gi = 0; gi < NUM_CFG; gi++) begin : g_eff
        logic [CW-1:0] raw;
        assign raw = CW'(cfg_reg[gi]);
        assign eff_dim[gi] = (raw == '0)    ? EW'(1) :
                             (raw > DIM_TOP) ? EW'(DIM_TOP) : EW'(raw);
    end

    logic [EW-1:0] chan_dim, width_dim, height_dim, depth_dim, batch_dim;
    assign chan_dim   = eff_dim[CFG_CHANNELS];
    assign width_dim  = eff_dim[CFG_IN_WIDTH];
    assign height_dim = eff_dim[CFG_IN_HEIGHT];
    assign depth_dim  = eff_dim[CFG_IN_DEPTH];
    assign batch_dim  = eff_dim[CFG_BATCHES];

    // ------------------------------------------------------------------
    // Stride chain, one multiply per stage
    // ------------------------------------------------------------------
    logic [INDEX_BITS-1:0] chan_ext;
    logic [INDEX_BITS-1:0] row_stride_reg, slice_stride_reg, vol_stride_reg;
    logic [INDEX_BITS-1:0] row_chan_reg;

    assign chan_ext = INDEX_BITS'(chan_dim);

    always_ff @(posedge aclk) begin
        row_stride_reg   <= (chan_ext * INDEX_BITS'(width_dim)) << 1;
        slice_stride_reg <= (row_stride_reg * INDEX_BITS'(height_dim)) << 1;
        vol_stride_reg   <= (slice_stride_reg * INDEX_BITS'(depth_dim)) << 1;
        row_chan_reg     <= row_stride_reg + chan_ext;
    end

    // ------------------------------------------------------------------
    // Position counters, advanced on each accepted input transaction
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0] chan_reg, x_reg, y_reg, z_reg, batch_reg;
    logic [DIM_BITS-1:0] chan_next, x_next, y_next, z_next, batch_next;
    logic [EW-1:0]       chan_inc, x_inc, y_inc, z_inc, batch_inc;
    logic                wrap_c, wrap_x, wrap_y, wrap_z, wrap_b;
    logic                last_all;

    always_comb begin
        chan_inc  = {1'b0, chan_reg}  + EW'(1);
        x_inc     = {1'b0, x_reg}     + EW'(1);
        y_inc     = {1'b0, y_reg}     + EW'(1);
        z_inc     = {1'b0, z_reg}     + EW'(1);
        batch_inc = {1'b0, batch_reg} + EW'(1);
        wrap_c    = (chan_inc  >= chan_dim);
        wrap_x    = (x_inc     >= width_dim);
        wrap_y    = (y_inc     >= height_dim);
        wrap_z    = (z_inc     >= depth_dim);
        wrap_b    = (batch_inc >= batch_dim);
        last_all  = wrap_c && wrap_x && wrap_y && wrap_z && wrap_b;

        chan_next  = wrap_c ? '0 : chan_inc[DIM_BITS-1:0];
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        batch_next = batch_reg;
        // carry ripples outward only through wrapped counters
        if (wrap_c) begin
            x_next = wrap_x ? '0 : x_inc[DIM_BITS-1:0];
            if (wrap_x) begin
                y_next = wrap_y ? '0 : y_inc[DIM_BITS-1:0];
                if (wrap_y) begin
                    z_next = wrap_z ? '0 : z_inc[DIM_BITS-1:0];
                    if (wrap_z) begin
                        batch_next = wrap_b ? '0 : batch_inc[DIM_BITS-1:0];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Index pipeline
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic s1_load, s2_load, s3_load, s4_load, s5_load, emit_load;
    logic s_accept;

    logic [SAMPLE_BITS-1:0] s1_bits_reg, s2_bits_reg, s3_bits_reg;
    logic [SAMPLE_BITS-1:0] s4_bits_reg, s5_bits_reg;
    logic s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg, s5_last_reg;
    logic [DIM_BITS-1:0] s1_chan_reg, s1_x_reg, s1_y_reg, s1_z_reg, s1_b_reg;
    logic [INDEX_BITS-1:0] s2_pb_reg, s2_pz_reg, s2_py_reg, s2_px_reg;
    logic [INDEX_BITS-1:0] s3_a_reg, s3_b_reg, s4_base_reg;
    logic [INDEX_BITS-1:0] s5_plane0_reg, s5_plane1_reg;

    // output stage
    logic                   m_valid_reg;
    logic [COPY_BITS-1:0]   copy_reg;
    logic [INDEX_BITS-1:0]  plane0_reg, plane1_reg;
    logic [SAMPLE_BITS-1:0] bits_reg;
    logic                   last_all_reg;
    logic [INDEX_BITS-1:0]  copy_offset;

    assign emit_load = !m_valid_reg || (m_ready && (copy_reg == LAST_COPY));
    assign s5_load   = !s5_v_reg || emit_load;
    assign s4_load   = !s4_v_reg || s5_load;
    assign s3_load   = !s3_v_reg || s4_load;
    assign s2_load   = !s2_v_reg || s3_load;
    assign s1_load   = !s1_v_reg || s2_load;
    assign s_ready   = (settle_reg == '0) && s1_load;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            batch_reg <= '0;
        end else if (s_accept) begin
            chan_reg  <= chan_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            batch_reg <= batch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
        end else begin
            if (s1_load) s1_v_reg <= s_accept;
            if (s2_load) s2_v_reg <= s1_v_reg;
            if (s3_load) s3_v_reg <= s2_v_reg;
            if (s4_load) s4_v_reg <= s3_v_reg;
            if (s5_load) s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // capture sample and its position
        if (s1_load) begin
            s1_bits_reg <= s_sample_bits;
            s1_last_reg <= last_all;
            s1_chan_reg <= chan_reg;
            s1_x_reg    <= x_reg;
            s1_y_reg    <= y_reg;
            s1_z_reg    <= z_reg;
            s1_b_reg    <= batch_reg;
        end
        // one product per term of the block base
        if (s2_load) begin
            s2_bits_reg <= s1_bits_reg;
            s2_last_reg <= s1_last_reg;
            s2_pb_reg   <= INDEX_BITS'(s1_b_reg) * vol_stride_reg;
            s2_pz_reg   <= INDEX_BITS'(s1_z_reg) * (slice_stride_reg << 1);
            s2_py_reg   <= INDEX_BITS'(s1_y_reg) * (row_stride_reg << 1);
            s2_px_reg   <= INDEX_BITS'(s1_x_reg) * (chan_ext << 1)
                           + INDEX_BITS'(s1_chan_reg);
        end
        if (s3_load) begin
            s3_bits_reg <= s2_bits_reg;
            s3_last_reg <= s2_last_reg;
            s3_a_reg    <= s2_pb_reg + s2_pz_reg;
            s3_b_reg    <= s2_py_reg + s2_px_reg;
        end
        if (s4_load) begin
            s4_bits_reg <= s3_bits_reg;
            s4_last_reg <= s3_last_reg;
            s4_base_reg <= s3_a_reg + s3_b_reg;
        end
        // base of the near plane and of the far plane
        if (s5_load) begin
            s5_bits_reg   <= s4_bits_reg;
            s5_last_reg   <= s4_last_reg;
            s5_plane0_reg <= s4_base_reg;
            s5_plane1_reg <= s4_base_reg + slice_stride_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: eight copies per sample
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            copy_reg    <= FIRST_COPY;
        end else if (emit_load) begin
            m_valid_reg <= s5_v_reg;
            copy_reg    <= FIRST_COPY;
        end else if (m_ready) begin
            copy_reg    <= copy_reg + COPY_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            plane0_reg   <= s5_plane0_reg;
            plane1_reg   <= s5_plane1_reg;
            bits_reg     <= s5_bits_reg;
            last_all_reg <= s5_last_reg;
        end
    end

    // dx and dy select the in-plane offset
    always_comb begin
        case (copy_reg[1:0])
            2'd0:    copy_offset = '0;
            2'd1:    copy_offset = chan_ext;
            2'd2:    copy_offset = row_stride_reg;
            default: copy_offset = row_chan_reg;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_out_index       = (copy_reg[2] ? plane1_reg : plane0_reg) + copy_offset;
    assign m_out_bits        = bits_reg;
    assign m_last_of_item    = (copy_reg == LAST_COPY);
    assign m_end_of_transfer = (copy_reg == LAST_COPY) && last_all_reg;

endmodule

// ===== design/nu3_checker.sv =====
// ----------------------------------------------------------------------------
// nu3_checker
// Port-level checks for the 3-D nearest-neighbor 2x upsampler, bound to the
// top level.
// ----------------------------------------------------------------------------
module nu3_checker #(
    parameter int INDEX_BITS = 40
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [INDEX_BITS-1:0]              m_out_index,
    input logic [nu3_pkg::SAMPLE_BITS-1:0]    m_out_bits,
    input logic                               m_last_of_item,
    input logic                               m_end_of_transfer
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_index)
                                && $stable(m_out_bits) && $stable(m_last_of_item)
                                && $stable(m_end_of_transfer))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_transfer |-> m_last_of_item)
        else $error("end of transfer off the last copy");

    // the copies of one sample follow without a gap and carry the same bits
    a_group_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_item |=>
            m_valid && (m_out_bits == $past(m_out_bits)))
        else $error("copy group broken");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("busy right after reset");

endmodule

bind nearest_upsample_3d_x2 nu3_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_nu3_checker (.*);
